@@ rtl/core/dda_pkg.sv @@
package dda_pkg;

  localparam int COORD_BITS_DEF     = 12;
  localparam int STEP_FRAC_BITS_DEF = 16;
  localparam int IN_FRAC_BITS       = 8;
  localparam int COLOR_BITS         = 24;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_SQ_X,
    S_SQ_Y,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_COMMIT
  } dda_state_t;

  typedef struct packed {
    logic load;
    logic delta;
    logic sq_x;
    logic sq_y;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic commit;
    logic emit;
  } dda_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic pix_nonzero;
    logic out_free;
  } dda_status_t;

endpackage

@@ rtl/core/dda_ctrl.sv @@
module dda_ctrl #(
  parameter int COORD_BITS     = dda_pkg::COORD_BITS_DEF,
  parameter int STEP_FRAC_BITS = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tuser,
  output logic                s_tready,
  input  dda_pkg::dda_status_t status,
  output dda_pkg::dda_cmd_t    cmd
);
  import dda_pkg::*;

  localparam int ROOT_W = COORD_BITS + IN_FRAC_BITS + 1;
  localparam int MAG_W  = COORD_BITS + STEP_FRAC_BITS;
  localparam int ITER_MAX = (MAG_W > ROOT_W) ? MAG_W : ROOT_W;
  localparam int ITER_W = $clog2(ITER_MAX);

  dda_state_t        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  assign accept = s_tvalid && status.out_free;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = status.out_free;
        if (accept) begin
          if (s_tuser == OP_LOAD) begin
            cmd.load   = 1'b1;
            state_next = S_DELTA;
          end else if (status.pix_nonzero) begin
            cmd.emit = 1'b1;
          end
        end
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.sq_y   = 1'b1;
        iter_next  = ITER_W'(ROOT_W - 1);
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter == '0) begin
          state_next = S_DIV_INIT;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_DIV_INIT: begin
        // zero-length line skips the divide, steps are forced to zero
        if (status.len_zero) begin
          state_next = S_COMMIT;
        end else begin
          cmd.div_init = 1'b1;
          iter_next    = ITER_W'(MAG_W - 1);
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == '0) begin
          state_next = S_COMMIT;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/dda_datapath.sv @@
module dda_datapath #(
  parameter int COORD_BITS     = dda_pkg::COORD_BITS_DEF,
  parameter int STEP_FRAC_BITS = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dda_pkg::dda_cmd_t                      cmd,
  output dda_pkg::dda_status_t                   status,
  input  logic [COORD_BITS+dda_pkg::IN_FRAC_BITS-1:0] start_x,
  input  logic [COORD_BITS+dda_pkg::IN_FRAC_BITS-1:0] start_y,
  input  logic [COORD_BITS+dda_pkg::IN_FRAC_BITS-1:0] end_x,
  input  logic [COORD_BITS+dda_pkg::IN_FRAC_BITS-1:0] end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0]         line_color,
  input  logic                                   m_tready,
  output logic                                   out_valid,
  output logic [COORD_BITS-1:0]                  pixel_x,
  output logic [COORD_BITS-1:0]                  pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0]         pixel_color,
  output logic                                   last_pixel
);
  import dda_pkg::*;

  localparam int IN_W     = COORD_BITS + IN_FRAC_BITS;
  localparam int SQ_W     = 2 * IN_W + 2;
  localparam int ROOT_W   = IN_W + 1;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_W    = COORD_BITS + 1;
  localparam int MAG_W    = COORD_BITS + STEP_FRAC_BITS;
  localparam int POS_W    = COORD_BITS + STEP_FRAC_BITS;
  localparam int STEP_W   = POS_W + 1;
  localparam int UP_SHIFT = STEP_FRAC_BITS - IN_FRAC_BITS;

  // captured line request
  logic [IN_W-1:0]       sx, sy, ex, ey;
  logic [COLOR_BITS-1:0] color_in;

  logic [IN_W-1:0] adx, ady;
  logic            neg_x, neg_y;
  logic [IN_W:0]   dx, dy;

  // shared squarer and radicand / sqrt shift register
  logic [IN_W-1:0]   mul_a;
  logic [2*IN_W-1:0] prod;
  logic [SQ_W-1:0]   acc;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [REM_W+1:0]  sq_trial, sq_sub;
  logic              sq_ge;
  logic [CNT_W-1:0]  cnt;

  // two restoring dividers, quotient shifts into the dividend register
  logic [MAG_W-1:0] dvx, dvy;
  logic [CNT_W-1:0] rmx, rmy;
  logic [CNT_W:0]   tx, ty;
  logic             gex, gey;

  logic [POS_W-1:0]  pos_x, pos_y;
  logic [STEP_W-1:0] step_x, step_y;
  logic [CNT_W-1:0]  pixels_left;
  logic [COLOR_BITS-1:0] held_color;

  assign dx = {1'b0, ex} - {1'b0, sx};
  assign dy = {1'b0, ey} - {1'b0, sy};

  assign mul_a = cmd.sq_y ? ady : adx;
  assign prod  = mul_a * mul_a;

  assign sq_trial = {rem, acc[SQ_W-1 -: 2]};
  assign sq_sub   = (REM_W + 2)'({root, 2'b01});
  assign sq_ge    = sq_trial >= sq_sub;

  assign cnt = root[ROOT_W-1:IN_FRAC_BITS];

  assign tx  = {rmx, dvx[MAG_W-1]};
  assign ty  = {rmy, dvy[MAG_W-1]};
  assign gex = tx >= {1'b0, cnt};
  assign gey = ty >= {1'b0, cnt};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx       <= start_x;
      sy       <= start_y;
      ex       <= end_x;
      ey       <= end_y;
      color_in <= line_color;
    end
    if (cmd.delta) begin
      neg_x <= dx[IN_W];
      neg_y <= dy[IN_W];
      adx   <= dx[IN_W] ? IN_W'(-dx) : dx[IN_W-1:0];
      ady   <= dy[IN_W] ? IN_W'(-dy) : dy[IN_W-1:0];
      rem   <= '0;
      root  <= '0;
    end
    if (cmd.sq_x) begin
      acc <= {2'b00, prod};
    end else if (cmd.sq_y) begin
      acc <= acc + {2'b00, prod};
    end else if (cmd.sqrt_step) begin
      acc  <= {acc[SQ_W-3:0], 2'b00};
      rem  <= sq_ge ? REM_W'(sq_trial - sq_sub) : REM_W'(sq_trial);
      root <= {root[ROOT_W-2:0], sq_ge};
    end
    if (cmd.div_init) begin
      dvx <= MAG_W'(adx) << UP_SHIFT;
      dvy <= MAG_W'(ady) << UP_SHIFT;
      rmx <= '0;
      rmy <= '0;
    end else if (cmd.div_step) begin
      rmx <= gex ? CNT_W'(tx - {1'b0, cnt}) : tx[CNT_W-1:0];
      rmy <= gey ? CNT_W'(ty - {1'b0, cnt}) : ty[CNT_W-1:0];
      dvx <= {dvx[MAG_W-2:0], gex};
      dvy <= {dvy[MAG_W-2:0], gey};
    end
    if (cmd.commit) begin
      pos_x      <= POS_W'(sx) << UP_SHIFT;
      pos_y      <= POS_W'(sy) << UP_SHIFT;
      held_color <= color_in;
      if (status.len_zero) begin
        step_x <= '0;
        step_y <= '0;
      end else begin
        step_x <= neg_x ? -STEP_W'(dvx) : STEP_W'(dvx);
        step_y <= neg_y ? -STEP_W'(dvy) : STEP_W'(dvy);
      end
    end else if (cmd.emit) begin
      pos_x <= pos_x + step_x[POS_W-1:0];
      pos_y <= pos_y + step_y[POS_W-1:0];
    end
    if (cmd.emit) begin
      pixel_x     <= pos_x[POS_W-1:STEP_FRAC_BITS];
      pixel_y     <= pos_y[POS_W-1:STEP_FRAC_BITS];
      pixel_color <= held_color;
      last_pixel  <= pixels_left == CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pixels_left <= cnt;
      end else if (cmd.emit) begin
        pixels_left <= pixels_left - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.len_zero    = cnt == '0;
  assign status.pix_nonzero = pixels_left != '0;
  assign status.out_free    = !out_valid || m_tready;

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || m_tready))
    else $error("pixel written over an untaken result");

  a_emit_needs_pixels: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> pixels_left == $past(pixels_left) - 1'b1 && $past(pixels_left) != '0)
    else $error("pixel emitted with no pixels left");

  a_zero_len_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.len_zero) |=> (pixels_left == '0 && step_x == '0 && step_y == '0))
    else $error("zero-length line left pixels or steps");

endmodule

@@ rtl/core/dda_line_rasterizer.sv @@
// channel | dir | handshake          | tuser   | tdata (low bit up)                 | tlast
// s       | in  | s_tvalid/s_tready  | opcode  | start_x start_y end_x end_y color  | -
// m       | out | m_tvalid/m_tready  | -       | pixel_x pixel_y pixel_color        | last_pixel
//
// step requests are taken back to back while the block is idle and the result register
// is empty or being drained, so pixels stream at one per cycle
// a load request occupies the block through its delta, squaring, bit-serial square root,
// restoring divide and commit steps; a zero-length line skips the divide
// a step request with no pixels left is taken and produces nothing
// rst is synchronous and clears the controller, the pixel count and the result valid
module dda_line_rasterizer #(
  parameter int COORD_BITS     = dda_pkg::COORD_BITS_DEF,
  parameter int STEP_FRAC_BITS = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [((4*(COORD_BITS+dda_pkg::IN_FRAC_BITS)+dda_pkg::COLOR_BITS+7)/8)*8-1:0]
               s_tdata,
  // opcode
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [((2*COORD_BITS+dda_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);
  import dda_pkg::*;

  localparam int IN_W        = COORD_BITS + IN_FRAC_BITS;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

  dda_cmd_t    cmd;
  dda_status_t status;

  logic [COORD_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;

  dda_ctrl #(
    .COORD_BITS     (COORD_BITS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dda_datapath #(
    .COORD_BITS     (COORD_BITS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_x     (s_tdata[0*IN_W +: IN_W]),
    .start_y     (s_tdata[1*IN_W +: IN_W]),
    .end_x       (s_tdata[2*IN_W +: IN_W]),
    .end_y       (s_tdata[3*IN_W +: IN_W]),
    .line_color  (s_tdata[4*IN_W +: COLOR_BITS]),
    .m_tready    (m_tready),
    .out_valid   (m_tvalid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'({pixel_color, pixel_y, pixel_x});

endmodule
